### rtl/core/fbpa_pkg.sv
// Shared widths, reset values, codes and state encoding for the block pool allocator.
package fbpa_pkg;

	localparam int MAX_BLOCKS_DEF = 256;

	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int BCNT_W     = 9;
	localparam int FCNT_W     = 8;
	localparam int USED_W     = 9;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;

	localparam logic [SIZE_W-1:0] MIN_BLOCK_SIZE = 16'd4;
	localparam logic [ADDR_W-1:0] BASE_RST       = 32'd0;
	localparam logic [SIZE_W-1:0] SIZE_RST       = 16'd64;
	localparam logic [BCNT_W-1:0] COUNT_RST      = 9'd256;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_TOO_BIG   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_BAD_COUNT = 3'd3,
		ST_BAD_ADDR  = 3'd4,
		ST_NONE_USED = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE  = 2'd0,
		CFG_SIZE  = 2'd1,
		CFG_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_FREE_CHK,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_DONE
	} state_t;

endpackage

### rtl/core/fixed_block_pool_allocator_top.sv
// Top level of the fixed-size block pool allocator: sequencer, link memory and counters.
//
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     tdata: request_size, free_address, free_count;
//                                        tuser: func
// m_*       out  m_tvalid / m_tready     tdata: block_address, used_now, used_peak;
//                                        tuser: status
// cfg_*     in   cfg_wen                 cfg_index, cfg_wdata
//
// Allocate: from accept to result register through check, link read, commit and load.
// Free: from accept to result register through check, the 32-step serial divider on the
// address offset, the free check and load.
// Reset and every register write start a clearing pass over all MAX_BLOCKS link entries
// that rebuilds the free chain in the link memory; no beat is accepted during it.
// One request at a time; a held result stalls the final load and with it the next accept.
module fixed_block_pool_allocator_top import fbpa_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // request_size, free_address, free_count
	input  logic                  s_tuser,   // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // block_address, used_now, used_peak, zero pad
	output logic [STATUS_W-1:0]   m_tuser,   // status
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW    = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int PRD_W = AW + SIZE_W;
	localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(MAX_BLOCKS - 1);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [BCNT_W-1:0] count_q;

	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] in_use_q;
	logic [CNT_W-1:0] peak_q;
	logic [CNT_W-1:0] sweep_q;

	logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
	logic [CNT_W-1:0] link_rd_q;

	func_t             func_q;
	logic [SIZE_W-1:0] req_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [FCNT_W-1:0] fcnt_q;

	logic [PRD_W-1:0]  prod_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t           res_status_q;

	logic              m_valid_q;
	logic [ADDR_W-1:0] m_addr_q;
	status_t           m_status_q;
	logic [USED_W-1:0] m_now_q;
	logic [USED_W-1:0] m_peak_q;

	logic              cfg_hit;
	logic              in_acc;
	logic              out_free;
	logic [SIZE_W-1:0] bs_eff;
	logic [CNT_W-1:0]  n_eff;
	status_t           chk_status;
	logic              chk_pass;
	logic              div_start;
	logic              div_done;
	logic [ADDR_W-1:0] div_quo;
	logic [SIZE_W-1:0] div_rem;
	logic [ADDR_W-1:0] offset;
	status_t           free_status;
	logic              free_pass;
	logic [AW-1:0]     free_blk;
	logic [CNT_W-1:0]  sweep_next;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CNT_W-1:0]  mem_wdata;
	logic [CNT_W-1:0]  in_use_inc;
	logic [31:0]       now_ext;
	logic [31:0]       peak_ext;

	assign cfg_hit  = cfg_wen && (cfg_index inside {CFG_BASE, CFG_SIZE, CFG_COUNT});
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign bs_eff   = (size_q < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : size_q;
	assign offset   = faddr_q - base_q;

	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(count_q) > 32'(MAX_BLOCKS)) begin
			n_eff = NULL_LINK;
		end else begin
			n_eff = CNT_W'(count_q);
		end
	end

	always_comb begin
		chk_status = ST_OK;
		if (func_q == FN_ALLOC) begin
			if (req_q > bs_eff) begin
				chk_status = ST_TOO_BIG;
			end else if (head_q >= NULL_LINK || in_use_q >= n_eff) begin
				chk_status = ST_EMPTY;
			end
		end else begin
			if (fcnt_q != FCNT_W'(1)) begin
				chk_status = ST_BAD_COUNT;
			end
		end
		chk_pass = (chk_status == ST_OK);
	end

	always_comb begin
		free_status = ST_OK;
		if (div_rem != '0 || div_quo >= 32'(n_eff)) begin
			free_status = ST_BAD_ADDR;
		end else if (in_use_q == '0) begin
			free_status = ST_NONE_USED;
		end
		free_pass = (free_status == ST_OK);
		free_blk  = div_quo[AW-1:0];
	end

	assign sweep_next = sweep_q + CNT_W'(1);
	assign in_use_inc = in_use_q + CNT_W'(1);

	fbpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (offset),
		.divisor   (bs_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_SWEEP: begin
				if (sweep_q == LAST_IDX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!chk_pass) begin
					state_d = S_DONE;
				end else if (func_q == FN_ALLOC) begin
					state_d = S_ALLOC_RD;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) state_d = S_FREE_CHK;
			end
			S_FREE_CHK: state_d = S_DONE;
			S_ALLOC_RD: state_d = S_ALLOC_WR;
			S_ALLOC_WR: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (cfg_hit) state_d = S_SWEEP;
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = sweep_q[AW-1:0];
		mem_wdata = (sweep_next < n_eff) ? sweep_next : NULL_LINK;
		case (state_q)
			S_SWEEP: mem_we = 1'b1;
			S_IDLE: s_tready = 1'b1;
			S_CHECK: div_start = chk_pass && (func_q == FN_FREE);
			S_FREE_CHK: begin
				mem_we    = free_pass;
				mem_waddr = free_blk;
				mem_wdata = head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RST;
			size_q   <= SIZE_RST;
			count_q  <= COUNT_RST;
			head_q   <= '0;
			in_use_q <= '0;
			peak_q   <= '0;
			sweep_q  <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_wdata[ADDR_W-1:0];
				CFG_SIZE:  size_q  <= cfg_wdata[SIZE_W-1:0];
				CFG_COUNT: count_q <= cfg_wdata[BCNT_W-1:0];
				default: ;
			endcase
			head_q   <= '0;
			in_use_q <= '0;
			peak_q   <= '0;
			sweep_q  <= '0;
		end else begin
			case (state_q)
				S_SWEEP: sweep_q <= sweep_next;
				S_ALLOC_WR: begin
					head_q   <= link_rd_q;
					in_use_q <= in_use_inc;
					if (peak_q < in_use_inc) peak_q <= in_use_inc;
				end
				S_FREE_CHK: begin
					if (free_pass) begin
						head_q   <= CNT_W'(free_blk);
						in_use_q <= in_use_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) link_mem[mem_waddr] <= mem_wdata;
		link_rd_q <= link_mem[head_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= func_t'(s_tuser);
			req_q   <= s_tdata[15:0];
			faddr_q <= s_tdata[47:16];
			fcnt_q  <= s_tdata[55:48];
		end
		case (state_q)
			S_CHECK: begin
				res_status_q <= chk_status;
				res_addr_q   <= '0;
			end
			S_ALLOC_RD: prod_q <= PRD_W'(head_q[AW-1:0]) * PRD_W'(bs_eff);
			S_ALLOC_WR: begin
				res_status_q <= ST_OK;
				res_addr_q   <= base_q + ADDR_W'(prod_q);
			end
			S_FREE_CHK: res_status_q <= free_status;
			default: ;
		endcase
	end

	assign now_ext  = 32'(in_use_q);
	assign peak_ext = 32'(peak_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_addr_q   <= res_addr_q;
			m_status_q <= res_status_q;
			m_now_q    <= now_ext[USED_W-1:0];
			m_peak_q   <= peak_ext[USED_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_DATA_W - ADDR_W - 2 * USED_W)'(0), m_peak_q, m_now_q, m_addr_q};
	assign m_tuser  = m_status_q;

endmodule

### rtl/core/fbpa_div.sv
// Serial restoring divider, one quotient bit per cycle, for the free address check.
module fbpa_div import fbpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [ADDR_W-1:0] quotient,
	output logic [SIZE_W-1:0] remainder
);

	localparam int STEP_W = $clog2(ADDR_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [ADDR_W-1:0] quo_q;
	logic [SIZE_W-1:0] rem_q;

	logic [SIZE_W:0]   rem_sh;
	logic [SIZE_W+1:0] diff;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[ADDR_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
	assign fits   = ~diff[SIZE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ADDR_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
			quo_q <= {quo_q[ADDR_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
